// ----- hw/rtl/lfu_cache_lru_tiebreak_unit_defines.svh -----
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef LFU_CACHE_LRU_TIEBREAK_UNIT_DEFINES_SVH
`define LFU_CACHE_LRU_TIEBREAK_UNIT_DEFINES_SVH

// same-cycle implication
`define LFU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lfu_pkg.sv -----
package lfu_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 32;
	localparam int CAP_W = 5;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic MODE_TOUCH  = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;
	localparam logic [CNT_W-1:0] CNT_ONE = 32'd1;
	localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic key_match;
		logic victim_better;
		logic rank_write;
	} lfu_flags_t;

endpackage

// ----- hw/rtl/lfu_ram.sv -----
module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/lfu_entry_unit.sv -----
module lfu_entry_unit #(
	parameter int IDX_W = 4
) (
	input  logic                       sweep_mode,
	input  logic                       entry_valid,
	input  logic [IDX_W-1:0]           entry_idx,
	input  logic [lfu_pkg::KEY_W-1:0]  entry_key,
	input  logic [lfu_pkg::CNT_W-1:0]  entry_count,
	input  logic [IDX_W-1:0]           entry_rank,
	input  logic [lfu_pkg::KEY_W-1:0]  lookup_key,
	input  logic                       have_best,
	input  logic [lfu_pkg::CNT_W-1:0]  best_count,
	input  logic [IDX_W-1:0]           best_rank,
	input  logic                       skip_en,
	input  logic [IDX_W-1:0]           ref_idx,
	input  logic [IDX_W-1:0]           ref_rank,
	output lfu_pkg::lfu_flags_t        flags,
	output logic [IDX_W-1:0]           rank_next
);

	import lfu_pkg::*;

	logic skip;
	logic older_than_ref;

	assign skip           = skip_en && (entry_idx == ref_idx);
	assign older_than_ref = entry_rank > ref_rank;

	always_comb begin
		flags.key_match     = entry_valid && (entry_key == lookup_key);
		flags.victim_better = entry_valid && (!have_best || (entry_count < best_count) ||
			((entry_count == best_count) && (entry_rank > best_rank)));
		if (sweep_mode == MODE_TOUCH) begin
			flags.rank_write = entry_valid && !skip && (entry_rank < ref_rank);
			rank_next        = entry_rank + IDX_W'(1);
		end else begin
			// drop of the victim and aging for the new entry in one pass
			flags.rank_write = entry_valid && !skip;
			rank_next        = (skip_en && older_than_ref) ? entry_rank
			                                               : entry_rank + IDX_W'(1);
		end
	end

endmodule

// ----- hw/rtl/lfu_cache_lru_tiebreak_unit.sv -----
// LFU cache with LRU tie-break, fully associative, ENTRIES slots.
// Command channel: drive op, key and value with start high; the transaction is
// taken at a rising edge with start high and busy low. busy stays high until
// the result is out.
// Result channel: done is high for one cycle with hit, read_value, evicted and
// evicted_key valid in that cycle. There is no backpressure; the receiver
// must take the result in that cycle.
// Config: cfg_we with cfg_data writes capacity; write only while idle.
// Sequence: every transaction first scans all entries one per cycle through the
// shared compare unit and then decides. A get miss or an ignored put then
// reports. A hit or an insert also sweeps the age ranks through the same unit
// one entry per cycle and then writes the entry before reporting. busy is low
// in the done cycle, so a new transaction can be taken at the edge that ends it.
// Reset: all entries invalid, capacity 16, block idle, no result pending.
`include "lfu_cache_lru_tiebreak_unit_defines.svh"

module lfu_cache_lru_tiebreak_unit #(
	parameter int ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic [lfu_pkg::KEY_W-1:0]         key,
	input  logic signed [lfu_pkg::VAL_W-1:0]  value,
	input  logic                              cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_data,
	output logic                              done,
	output logic                              hit,
	output logic signed [lfu_pkg::VAL_W-1:0]  read_value,
	output logic                              evicted,
	output logic [lfu_pkg::KEY_W-1:0]         evicted_key
);

	import lfu_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SWEEP  = 3'd3;
	localparam logic [2:0] ST_FINAL  = 3'd4;

	logic [2:0]              state_q;
	logic [CAP_W-1:0]        capacity_q;
	logic [ENTRIES-1:0]      valid_q;
	logic [IW-1:0]           ptr_q;
	logic                    issue_q;
	logic                    rd_vld_s1;
	logic [IW-1:0]           rd_idx_s1;

	logic                    op_q;
	logic [KEY_W-1:0]        key_q;
	logic [VAL_W-1:0]        value_q;

	logic                    hit_q;
	logic [IW-1:0]           fidx_q;
	logic [IW-1:0]           frank_q;
	logic [VAL_W-1:0]        fval_q;
	logic [CNT_W-1:0]        fcnt_q;
	logic                    have_v_q;
	logic [IW-1:0]           vidx_q;
	logic [IW-1:0]           vrank_q;
	logic [CNT_W-1:0]        vcnt_q;
	logic [KEY_W-1:0]        vkey_q;
	logic                    have_free_q;
	logic [IW-1:0]           free_q;
	logic [UW-1:0]           used_q;

	logic                    mode_q;
	logic [IW-1:0]           slot_q;
	logic                    ev_q;
	logic [KEY_W-1:0]        evk_q;
	logic signed [VAL_W-1:0] rd_q;
	logic                    done_q;

	logic [KEY_W-1:0]        key_rd;
	logic [VAL_W-1:0]        val_rd;
	logic [CNT_W-1:0]        cnt_rd;
	logic [IW-1:0]           age_rd;
	lfu_flags_t              flags;
	logic [IW-1:0]           rank_next;
	logic                    ent_valid;
	logic                    skip_en;
	logic [IW-1:0]           ref_idx;
	logic [IW-1:0]           ref_rank;

	logic                    full;
	logic                    ev_now;
	logic [IW-1:0]           slot_now;
	logic [IW-1:0]           tgt;
	logic                    accept;
	logic                    sweep_go;

	logic                    key_we;
	logic                    val_we;
	logic                    cnt_we;
	logic                    age_we;
	logic [IW-1:0]           age_waddr;
	logic [IW-1:0]           age_wdata;
	logic [CNT_W-1:0]        cnt_wdata;

	assign accept    = start && (state_q == ST_IDLE);
	assign ent_valid = valid_q[rd_idx_s1];
	assign sweep_go  = hit_q || ((op_q == OP_PUT) && (capacity_q != '0));

	assign skip_en  = (mode_q == MODE_TOUCH) || ev_q;
	assign ref_idx  = (mode_q == MODE_TOUCH) ? fidx_q : vidx_q;
	assign ref_rank = (mode_q == MODE_TOUCH) ? frank_q : vrank_q;

	assign full     = (32'(used_q) >= 32'(capacity_q)) || (used_q == UW'(ENTRIES));
	assign ev_now   = have_v_q && full;
	assign slot_now = (ev_now && (!have_free_q || (vidx_q < free_q))) ? vidx_q : free_q;
	assign tgt      = (mode_q == MODE_TOUCH) ? fidx_q : slot_q;

	lfu_entry_unit #(
		.IDX_W (IW)
	) u_unit (
		.sweep_mode  (mode_q),
		.entry_valid (ent_valid),
		.entry_idx   (rd_idx_s1),
		.entry_key   (key_rd),
		.entry_count (cnt_rd),
		.entry_rank  (age_rd),
		.lookup_key  (key_q),
		.have_best   (have_v_q),
		.best_count  (vcnt_q),
		.best_rank   (vrank_q),
		.skip_en     (skip_en),
		.ref_idx     (ref_idx),
		.ref_rank    (ref_rank),
		.flags       (flags),
		.rank_next   (rank_next)
	);

	always_comb begin
		key_we    = (state_q == ST_FINAL) && (mode_q == MODE_INSERT);
		val_we    = (state_q == ST_FINAL) && (op_q == OP_PUT);
		cnt_we    = (state_q == ST_FINAL);
		cnt_wdata = (mode_q == MODE_INSERT) ? CNT_ONE :
		            (fcnt_q == CNT_MAX)     ? fcnt_q : fcnt_q + CNT_ONE;
		if (state_q == ST_FINAL) begin
			age_we    = 1'b1;
			age_waddr = tgt;
			age_wdata = '0;
		end else begin
			age_we    = (state_q == ST_SWEEP) && rd_vld_s1 && flags.rank_write;
			age_waddr = rd_idx_s1;
			age_wdata = rank_next;
		end
	end

	lfu_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (slot_q),
		.wdata (key_q),
		.raddr (ptr_q),
		.rdata (key_rd)
	);

	lfu_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (tgt),
		.wdata (value_q),
		.raddr (ptr_q),
		.rdata (val_rd)
	);

	lfu_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (tgt),
		.wdata (cnt_wdata),
		.raddr (ptr_q),
		.rdata (cnt_rd)
	);

	lfu_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (age_waddr),
		.wdata (age_wdata),
		.raddr (ptr_q),
		.rdata (age_rd)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= CAP_RESET;
			valid_q    <= '0;
			ptr_q      <= '0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= ((state_q == ST_DECIDE) && !sweep_go) || (state_q == ST_FINAL);
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end

			if (issue_q) begin
				rd_vld_s1 <= 1'b1;
				if (ptr_q == LAST) begin
					issue_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + IW'(1);
				end
			end else begin
				rd_vld_s1 <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						ptr_q   <= '0;
						issue_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1 && (rd_idx_s1 == LAST)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (sweep_go) begin
						state_q <= ST_SWEEP;
						ptr_q   <= '0;
						issue_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (rd_vld_s1 && (rd_idx_s1 == LAST)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					// victim out, new entry in; the new slot may be the victim's
					if (mode_q == MODE_INSERT) begin
						valid_q <= (valid_q & ~(ENTRIES'(ev_q) << vidx_q)) |
						           (ENTRIES'(1) << slot_q);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q;
		if (accept) begin
			op_q        <= op;
			key_q       <= key;
			value_q     <= value;
			hit_q       <= 1'b0;
			have_v_q    <= 1'b0;
			have_free_q <= 1'b0;
			used_q      <= '0;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (ent_valid) begin
				used_q <= used_q + UW'(1);
			end
			if (flags.key_match && !hit_q) begin
				hit_q   <= 1'b1;
				fidx_q  <= rd_idx_s1;
				frank_q <= age_rd;
				fval_q  <= val_rd;
				fcnt_q  <= cnt_rd;
			end
			if (flags.victim_better) begin
				have_v_q <= 1'b1;
				vidx_q   <= rd_idx_s1;
				vrank_q  <= age_rd;
				vcnt_q   <= cnt_rd;
				vkey_q   <= key_rd;
			end
			if (!ent_valid && !have_free_q) begin
				have_free_q <= 1'b1;
				free_q      <= rd_idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			slot_q <= slot_now;
			if (hit_q) begin
				mode_q <= MODE_TOUCH;
				ev_q   <= 1'b0;
				evk_q  <= '0;
				rd_q   <= (op_q == OP_GET) ? $signed(fval_q) : MISS_VALUE;
			end else if ((op_q == OP_PUT) && (capacity_q != '0)) begin
				mode_q <= MODE_INSERT;
				ev_q   <= ev_now;
				evk_q  <= ev_now ? vkey_q : '0;
				rd_q   <= MISS_VALUE;
			end else begin
				mode_q <= MODE_TOUCH;
				ev_q   <= 1'b0;
				evk_q  <= '0;
				rd_q   <= MISS_VALUE;
			end
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign hit         = hit_q;
	assign read_value  = rd_q;
	assign evicted     = ev_q;
	assign evicted_key = evk_q;

	`LFU_ASSERT_NXT(a_done_one_cycle, done_q, !done_q, "result strobe held too long")
	`LFU_ASSERT_IMP(a_done_when_idle, done_q, state_q == ST_IDLE, "result strobe while busy")
	`LFU_ASSERT_NXT(a_accept_scans, start && !busy, state_q == ST_SCAN, "no scan after accept")
	`LFU_ASSERT_IMP(a_evict_put_miss, done_q && ev_q, !hit_q && op_q == OP_PUT, "bad eviction")

endmodule
